// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files of the event stream parser.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SSE_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// A condition that must hold in the cycle after a trigger.
`define SSE_ASSERT_NEXT(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

// ===== sv/sse_pkg.sv =====
// Types, codes and character constants of the event stream parser.
// Depends on nothing; the front end, command queue, line engine and top level import it.
package sse_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_EOL   = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_cmd_beat;

    typedef struct packed {
        logic      valid;
        t_cmd_beat beat;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_COPY,
        ST_SEND,
        ST_ERROR
    } t_back_state;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE            = 2'd0;
    localparam logic [1:0] ERR_LINE_TOO_LONG   = 2'd1;
    localparam logic [1:0] ERR_EVENT_TOO_LARGE = 2'd2;

    localparam logic [2:0] EVENT_WORD_LEN = 3'd5;
    localparam logic [2:0] DATA_WORD_LEN  = 3'd4;
    localparam logic [2:0] DEFAULT_NAME_LEN = 3'd7;

    function automatic logic [7:0] event_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h65;
            3'd1:    c = 8'h76;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h6E;
            default: c = 8'h74;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] data_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h64;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h74;
            default: c = 8'h61;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] message_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h6D;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h73;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h61;
            3'd5:    c = 8'h67;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/sse_if.sv =====
// Valid/ready channel interfaces of the event stream parser.
// Depends on nothing.
interface sse_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] in_byte;

    modport source (output valid, output action, output in_byte, input ready);
    modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface sse_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

// ===== sv/sse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/sse_front.sv =====
// Front end: accepts input beats and turns them into line commands.
// Depends on sse_pkg and sse_if.
module sse_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sse_in_if.sink             i_in,
    input  sse_pkg::t_fifo_stat i_stat,
    output sse_pkg::t_push      o_push
);
    import sse_pkg::*;

    logic r_after_cr;
    logic n_after_cr;
    t_cmd cmd;
    logic take;

    assign take = i_in.valid && !i_stat.full;
    assign i_in.ready = !i_stat.full;

    always_comb begin
        n_after_cr = r_after_cr;
        if (i_in.action) begin
            cmd = CMD_FLUSH;
        end else if (i_in.in_byte == CHAR_CR) begin
            cmd = CMD_EOL;
            n_after_cr = 1'b1;
        end else if (i_in.in_byte == CHAR_LF) begin
            // An LF right after a CR belongs to the same line end.
            cmd = r_after_cr ? CMD_NOP : CMD_EOL;
            n_after_cr = 1'b0;
        end else begin
            cmd = CMD_BYTE;
            n_after_cr = 1'b0;
        end
    end

    assign o_push.valid     = take;
    assign o_push.beat.cmd  = cmd;
    assign o_push.beat.data = i_in.in_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_cr <= 1'b0;
        end else if (take) begin
            r_after_cr <= n_after_cr;
        end
    end
endmodule

// ===== sv/sse_cmd_fifo.sv =====
// Short command queue between the front end and the line engine.
// Depends on sse_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sse_cmd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sse_pkg::t_push       i_push,
    input  logic                 i_pop,
    output sse_pkg::t_cmd_beat   o_head,
    output sse_pkg::t_fifo_stat  o_stat
);
    import sse_pkg::*;

    t_cmd_beat            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr;
    logic [FIFO_AW-1:0]   r_rptr;
    logic [FIFO_CW-1:0]   r_count;
    logic                 push;
    logic                 pop;

    assign o_stat.full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign push = i_push.valid && !o_stat.full;
    assign pop  = i_pop && !o_stat.empty;
    assign o_head = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push.beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + FIFO_CW'(1);
                2'b01:   r_count <= r_count - FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `SSE_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FIFO_CW'(FIFO_DEPTH))
    `SSE_ASSERT_NEXT(a_fill_to_full, i_clk, i_rst_n, push && !pop && r_count == FIFO_CW'(FIFO_DEPTH - 1), o_stat.full)
endmodule

// ===== sv/sse_back.sv =====
// Line engine: stores line bytes, parses finished lines, emits events and errors.
// Depends on sse_pkg, sse_if, sse_ram and assert_macros.svh.
`include "assert_macros.svh"
module sse_back #(
    parameter int LINE_BYTES = 64,
    parameter int NAME_BYTES = 16,
    parameter int DATA_BYTES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sse_pkg::t_cmd_beat  i_head,
    input  sse_pkg::t_fifo_stat i_stat,
    output logic                o_pop,
    sse_out_if.source           o_out
);
    import sse_pkg::*;

    localparam int LW  = $clog2(LINE_BYTES + 1);
    localparam int AW  = $clog2(LINE_BYTES);
    localparam int NW  = $clog2(NAME_BYTES + 1);
    localparam int NIW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int DW  = $clog2(DATA_BYTES + 1);
    localparam int DIW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int WW  = (DW > NW) ? DW : NW;
    localparam int EW  = (WW > 3) ? WW : 3;
    localparam int CW  = LW + 8;

    t_back_state r_state, n_state;
    logic [LW-1:0] r_llen, n_llen;
    logic [NW-1:0] r_nlen, n_nlen;
    logic [DW-1:0] r_plen, n_plen;
    logic [1:0]    r_err, n_err;
    logic          r_flush, n_flush;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [LW-1:0] r_pidx, n_pidx;
    logic [LW-1:0] r_sep, n_sep;
    logic          r_sep_found, n_sep_found;
    logic          r_sp, n_sp;
    logic          r_ev_ok, n_ev_ok;
    logic          r_da_ok, n_da_ok;
    logic          r_to_name, n_to_name;
    logic [WW-1:0] r_wi, n_wi;
    logic [EW-1:0] r_eidx, n_eidx;
    logic          r_ephase, n_ephase;

    logic [7:0] r_name [NAME_BYTES];
    logic [7:0] r_data [DATA_BYTES];

    logic          r_ovalid;
    logic [1:0]    r_okind;
    logic [7:0]    r_obyte;
    logic          r_olast;

    logic          out_free;
    logic          emit;
    logic [1:0]    e_kind;
    logic [7:0]    e_byte;
    logic          e_last;

    logic          ram_we;
    logic [7:0]    ram_rdata;

    logic          name_we;
    logic [NIW-1:0] name_wa;
    logic          data_we;
    logic [DIW-1:0] data_wa;
    logic [7:0]    data_wd;

    assign out_free = !r_ovalid || o_out.ready;

    sse_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_llen[AW-1:0]),
        .i_wdata (i_head.data),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        logic [LW-1:0] vstart;
        logic [LW-1:0] vlen;
        logic [LW-1:0] sepv;
        logic [DW-1:0] plen_j;
        logic [EW-1:0] ncount;
        logic          fail;

        n_state = r_state;
        n_llen = r_llen;
        n_nlen = r_nlen;
        n_plen = r_plen;
        n_err = r_err;
        n_flush = r_flush;
        n_idx = r_idx;
        n_pend = 1'b0;
        n_pidx = r_idx;
        n_sep = r_sep;
        n_sep_found = r_sep_found;
        n_sp = r_sp;
        n_ev_ok = r_ev_ok;
        n_da_ok = r_da_ok;
        n_to_name = r_to_name;
        n_wi = r_wi;
        n_eidx = r_eidx;
        n_ephase = r_ephase;
        o_pop = 1'b0;
        emit = 1'b0;
        e_kind = KIND_ERROR;
        e_byte = {6'd0, r_err};
        e_last = 1'b1;
        ram_we = 1'b0;
        name_we = 1'b0;
        name_wa = r_wi[NIW-1:0];
        data_we = 1'b0;
        data_wa = r_wi[DIW-1:0];
        data_wd = ram_rdata;
        vstart = '0;
        vlen = '0;
        // A line without a colon is all field name and has an empty value.
        sepv = r_sep_found ? r_sep : r_llen;
        plen_j = r_plen;
        fail = 1'b0;
        ncount = (r_nlen == '0) ? EW'(DEFAULT_NAME_LEN) : EW'(r_nlen);

        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                n_eidx = '0;
                n_ephase = 1'b0;
                n_sep_found = 1'b0;
                n_sp = 1'b0;
                n_ev_ok = 1'b1;
                n_da_ok = 1'b1;
                if (r_err != ERR_NONE) begin
                    if (!i_stat.empty && out_free) begin
                        o_pop = 1'b1;
                        emit = 1'b1;
                    end
                end else if (!i_stat.empty) begin
                    o_pop = 1'b1;
                    unique case (i_head.cmd)
                        CMD_BYTE: begin
                            if (r_llen >= LW'(LINE_BYTES)) begin
                                n_err = ERR_LINE_TOO_LONG;
                                n_state = ST_ERROR;
                            end else begin
                                ram_we = 1'b1;
                                n_llen = r_llen + LW'(1);
                            end
                        end
                        CMD_EOL: begin
                            n_flush = 1'b0;
                            n_state = (r_llen == '0) ? ST_SEND : ST_SCAN;
                        end
                        CMD_FLUSH: begin
                            n_flush = 1'b1;
                            if (r_llen != '0) begin
                                n_state = ST_SCAN;
                            end else if (r_plen != '0) begin
                                n_state = ST_SEND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (r_idx < r_llen) begin
                    n_idx = r_idx + LW'(1);
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    if (r_pidx < LW'(EVENT_WORD_LEN)
                            && ram_rdata != event_char(r_pidx[2:0])) begin
                        n_ev_ok = 1'b0;
                    end
                    if (r_pidx < LW'(DATA_WORD_LEN)
                            && ram_rdata != data_char(r_pidx[2:0])) begin
                        n_da_ok = 1'b0;
                    end
                    if (!r_sep_found && ram_rdata == CHAR_COLON) begin
                        n_sep_found = 1'b1;
                        n_sep = r_pidx;
                    end else if (r_sep_found && r_pidx == r_sep + LW'(1)
                            && ram_rdata == CHAR_SPACE) begin
                        n_sp = 1'b1;
                    end
                end else if (!(r_idx < r_llen)) begin
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                vstart = r_sep_found ? (r_sep + LW'(1) + LW'(r_sp)) : r_llen;
                vlen = r_llen - vstart;
                n_idx = vstart;
                if (sepv == LW'(EVENT_WORD_LEN) && r_ev_ok) begin
                    if (CW'(vlen) > CW'(NAME_BYTES)) begin
                        n_err = ERR_LINE_TOO_LONG;
                        n_state = ST_ERROR;
                    end else begin
                        n_nlen = NW'(vlen);
                        n_to_name = 1'b1;
                        n_wi = '0;
                        n_state = ST_COPY;
                    end
                end else if (sepv == LW'(DATA_WORD_LEN) && r_da_ok) begin
                    if (r_plen != '0) begin
                        if (r_plen >= DW'(DATA_BYTES)) begin
                            fail = 1'b1;
                        end else begin
                            data_we = 1'b1;
                            data_wa = r_plen[DIW-1:0];
                            data_wd = CHAR_LF;
                            plen_j = r_plen + DW'(1);
                        end
                    end
                    if (!fail && CW'(vlen) > CW'(DATA_BYTES) - CW'(plen_j)) begin
                        fail = 1'b1;
                    end
                    if (fail) begin
                        n_err = ERR_EVENT_TOO_LARGE;
                        n_state = ST_ERROR;
                    end else begin
                        n_plen = DW'(CW'(plen_j) + CW'(vlen));
                        n_to_name = 1'b0;
                        n_wi = WW'(plen_j);
                        n_state = ST_COPY;
                    end
                end else begin
                    // Comment lines and unknown fields only clear the line.
                    n_llen = '0;
                    n_state = (r_flush && r_plen != '0) ? ST_SEND : ST_IDLE;
                end
            end

            ST_COPY: begin
                if (r_idx < r_llen) begin
                    n_idx = r_idx + LW'(1);
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    name_we = r_to_name;
                    data_we = !r_to_name;
                    n_wi = r_wi + WW'(1);
                end else if (!(r_idx < r_llen)) begin
                    n_llen = '0;
                    n_state = (r_flush && r_plen != '0) ? ST_SEND : ST_IDLE;
                end
            end

            ST_SEND: begin
                if (r_plen == '0) begin
                    n_nlen = '0;
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    emit = 1'b1;
                    e_last = 1'b0;
                    if (!r_ephase) begin
                        e_kind = KIND_NAME;
                        e_byte = (r_nlen == '0) ? message_char(r_eidx[2:0])
                                                : r_name[r_eidx[NIW-1:0]];
                        if (r_eidx == ncount - EW'(1)) begin
                            n_ephase = 1'b1;
                            n_eidx = '0;
                        end else begin
                            n_eidx = r_eidx + EW'(1);
                        end
                    end else begin
                        e_kind = KIND_DATA;
                        e_byte = r_data[r_eidx[DIW-1:0]];
                        if (r_eidx == EW'(r_plen) - EW'(1)) begin
                            e_last = 1'b1;
                            n_nlen = '0;
                            n_plen = '0;
                            n_state = ST_IDLE;
                        end else begin
                            n_eidx = r_eidx + EW'(1);
                        end
                    end
                end
            end

            ST_ERROR: begin
                if (out_free) begin
                    emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_llen <= '0;
            r_nlen <= '0;
            r_plen <= '0;
            r_err <= ERR_NONE;
            r_pend <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_llen <= n_llen;
            r_nlen <= n_nlen;
            r_plen <= n_plen;
            r_err <= n_err;
            r_pend <= n_pend;
            r_ovalid <= emit || (r_ovalid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_flush <= n_flush;
        r_idx <= n_idx;
        r_pidx <= n_pidx;
        r_sep <= n_sep;
        r_sep_found <= n_sep_found;
        r_sp <= n_sp;
        r_ev_ok <= n_ev_ok;
        r_da_ok <= n_da_ok;
        r_to_name <= n_to_name;
        r_wi <= n_wi;
        r_eidx <= n_eidx;
        r_ephase <= n_ephase;
        if (emit) begin
            r_okind <= e_kind;
            r_obyte <= e_byte;
            r_olast <= e_last;
        end
        if (name_we) begin
            r_name[name_wa] <= ram_rdata;
        end
        if (data_we) begin
            r_data[data_wa] <= data_wd;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.kind     = r_okind;
    assign o_out.out_byte = r_obyte;
    assign o_out.last     = r_olast;

    `SSE_ASSERT_ALWAYS(a_line_bound, i_clk, i_rst_n, r_llen <= LW'(LINE_BYTES))
    `SSE_ASSERT_ALWAYS(a_data_bound, i_clk, i_rst_n, r_plen <= DW'(DATA_BYTES))
    `SSE_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err != ERR_NONE, r_err == $past(r_err))
endmodule

// ===== sv/sse_event_stream_parser_top.sv =====
// Top level of the server-sent-events stream parser.
// Depends on sse_pkg, sse_if, sse_front, sse_cmd_fifo, sse_back and sse_ram.
//
// Usage: the input channel carries one beat per stream byte (action 0) or an
// end-of-stream mark (action 1). The output channel carries result beats:
// event name bytes, then event data bytes, the final one flagged by last, or
// a single error report beat with last set.
// Throughput: the line engine takes a plain line byte from the queue while it is
// idle. A finished line is handled in the line engine from when its line end
// leaves the queue: it scans the line RAM for the field and value, decides,
// then copies the value out. A line that is only dropped is scanned and
// decided. An event leaves at one beat per cycle while the receiver is ready.
// The single line engine handles one line at a time through the RAM read port.
// A four-entry command queue between the front end and the line engine lets
// bytes keep arriving while a line is parsed or an event is being sent;
// input ready drops only when that queue is full.
// A blank line that ends an event, or a byte that overflows the line, goes
// through the state register, then the output register; once the error is
// sticky, each later report is registered as its beat leaves the queue.
// Reset (synchronous, active low) empties the queue, clears all lengths and
// the sticky error; no clearing pass is needed.
// When the receiver stalls, the output register holds its beat, the line engine
// waits once it has a beat to send, and the queue then fills and back-pressures the input.
module sse_event_stream_parser_top #(
    parameter int LINE_BYTES = 64,
    parameter int NAME_BYTES = 16,
    parameter int DATA_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sse_in_if.sink     i_in,
    sse_out_if.source  o_out
);
    import sse_pkg::*;

    t_push      push;
    t_fifo_stat stat;
    t_cmd_beat  head;
    logic       pop;

    // Front end: classifies bytes, folds CR LF pairs.
    sse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (stat),
        .o_push  (push)
    );

    sse_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    // Line engine: owns the line, name and data stores and the output register.
    sse_back #(
        .LINE_BYTES (LINE_BYTES),
        .NAME_BYTES (NAME_BYTES),
        .DATA_BYTES (DATA_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule
